@@ rtl/uart_fbd_pkg.sv @@
// shared widths, constants and fraction tables for the fractional baud divisor
package uart_fbd_pkg;

    localparam int BAUD_W   = 22;
    localparam int CLK_W    = 32;
    localparam int DIV_W    = 25;
    localparam int PROD_W   = 39;
    localparam int QUO_W    = 15;
    localparam int CYC_W    = 9;
    localparam int TENTH_W  = 4;

    localparam logic [BAUD_W-1:0]  BAUD_RESET = 22'd115200;
    localparam logic [TENTH_W-1:0] MAX_TENTH  = 4'd10;

    function automatic logic [7:0] frac_low(input logic [TENTH_W-1:0] tenth);
        logic [7:0] w;
        case (tenth)
            4'd0:    w = 8'h00;
            4'd1:    w = 8'h01;
            4'd2:    w = 8'h05;
            4'd3:    w = 8'h15;
            4'd4:    w = 8'h55;
            4'd5:    w = 8'h57;
            4'd6:    w = 8'h57;
            4'd7:    w = 8'h77;
            4'd8:    w = 8'h7f;
            4'd9:    w = 8'hff;
            default: w = 8'hff;
        endcase
        return w;
    endfunction

    function automatic logic [1:0] frac_high(input logic [TENTH_W-1:0] tenth);
        logic [1:0] w;
        case (tenth)
            4'd6, 4'd7, 4'd8, 4'd9: w = 2'd1;
            4'd10:                  w = 2'd3;
            default:                w = 2'd0;
        endcase
        return w;
    endfunction

endpackage

@@ rtl/uart_fbd_divider.sv @@
// pipelined restoring divider, one quotient bit per stage, with side data
module uart_fbd_divider
    import uart_fbd_pkg::*;
#(
    parameter int DW = 22,
    parameter int QW = 25,
    parameter int SW = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] num_hi,
    input  logic [QW-1:0] num_lo,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [QW-1:0] quo,
    output logic [SW-1:0] side_out
);

    logic          valid_reg [QW+1];
    logic [DW-1:0] rem_reg   [QW+1];
    logic [QW-1:0] low_reg   [QW+1];
    logic [QW-1:0] quo_reg   [QW+1];
    logic [DW-1:0] den_reg   [QW+1];
    logic [SW-1:0] side_reg  [QW+1];

    logic [DW-1:0] rem_next [QW];
    logic [QW-1:0] quo_next [QW];

    always_comb
    begin
        for (int k = 0; k < QW; k++)
        begin
            logic [DW:0] t;
            t = {rem_reg[k], low_reg[k][QW-1-k]};
            if (t >= {1'b0, den_reg[k]})
            begin
                rem_next[k] = DW'(t - {1'b0, den_reg[k]});
                quo_next[k] = {quo_reg[k][QW-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = t[DW-1:0];
                quo_next[k] = {quo_reg[k][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QW; k++)
                valid_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 0; k < QW; k++)
                valid_reg[k+1] <= valid_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= num_hi;
            low_reg[0]  <= num_lo;
            quo_reg[0]  <= '0;
            den_reg[0]  <= den;
            side_reg[0] <= side_in;
            for (int k = 0; k < QW; k++)
            begin
                rem_reg[k+1]  <= rem_next[k];
                low_reg[k+1]  <= low_reg[k];
                quo_reg[k+1]  <= quo_next[k];
                den_reg[k+1]  <= den_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = valid_reg[QW];
    assign quo       = quo_reg[QW];
    assign side_out  = side_reg[QW];

endmodule

@@ rtl/uart_fractional_baud_divisor_core.sv @@
// top level of the fractional uart baud divisor calculator
// One item is a reference clock rate; it gives one result with the divisor, the overflow
// flag, the sample count and point and the two fraction table words for the baud rate
// register. The pipeline takes an item every cycle while the output is not stalled. It has
// an input stage, a 26-stage divider for the divisor, a multiply stage, a 16-stage divider
// for the scaled bit time, a reciprocal stage and the output register. A stall on the output
// holds the whole pipeline. Write baud_rate only while no item is in flight.
module uart_fractional_baud_divisor_core
    import uart_fbd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [BAUD_W-1:0] cfg_wdata,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CLK_W-1:0]  clock_hz,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [15:0]       divisor,
    output logic              divisor_overflow,
    output logic [7:0]        sample_count,
    output logic [7:0]        sample_point,
    output logic [7:0]        fraction_low,
    output logic [1:0]        fraction_high
);

    logic [BAUD_W-1:0] baud_reg;
    logic [BAUD_W-1:0] baud;
    logic              en;

    logic              v0_reg;
    logic [CLK_W-1:0]  clk0_reg;
    logic [DIV_W-1:0]  n1_reg;
    logic [32:0]       n1_sum;

    logic              v1;
    logic [DIV_W-1:0]  q1;
    logic [CLK_W-1:0]  clk1;

    logic              v2_reg;
    logic [DIV_W-1:0]  m_reg;
    logic [PROD_W-1:0] n2_reg;
    logic [DIV_W-1:0]  div2_reg;
    logic              zero2_reg;
    logic [46:0]       m_prod;

    logic              v3;
    logic [QUO_W-1:0]  q2;
    logic [DIV_W:0]    side3;

    logic              v4_reg;
    logic [QUO_W-1:0]  quo4_reg;
    logic [CYC_W-1:0]  cyc4_reg;
    logic [DIV_W-1:0]  div4_reg;
    logic              zero4_reg;
    logic [27:0]       recip;

    logic              out_valid_reg;
    logic [15:0]       divisor_reg;
    logic              overflow_reg;
    logic [7:0]        sc_reg;
    logic [7:0]        sp_reg;
    logic [7:0]        flow_reg;
    logic [1:0]        fhigh_reg;

    logic [QUO_W-1:0]  pct_wide;
    logic [6:0]        pct;
    logic [14:0]       tenth_prod;
    logic [TENTH_W-1:0] tenth;
    logic [7:0]        sc_next;
    logic [7:0]        sp_next;

    assign baud     = (baud_reg == '0) ? BAUD_W'(1) : baud_reg;
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = out_valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            baud_reg <= BAUD_RESET;
        else if (cfg_we)
            baud_reg <= cfg_wdata;
    end

    // ceil(clk / (256 * baud)) == floor((clk + 256 * baud - 1) / 256) / baud
    assign n1_sum = {1'b0, clock_hz} + {3'b000, baud, 8'h00} - 33'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg        <= in_valid;
            v2_reg        <= v1;
            v4_reg        <= v3;
            out_valid_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            clk0_reg <= clock_hz;
            n1_reg   <= n1_sum[32:8];
        end
    end

    uart_fbd_divider #(
        .DW (BAUD_W),
        .QW (DIV_W),
        .SW (CLK_W)
    ) u_div_baud (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v0_reg),
        .num_hi    ('0),
        .num_lo    (n1_reg),
        .den       (baud),
        .side_in   (clk0_reg),
        .out_valid (v1),
        .quo       (q1),
        .side_out  (clk1)
    );

    assign m_prod = 47'(baud) * 47'(q1);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg     <= m_prod[DIV_W-1:0];
            n2_reg    <= PROD_W'(clk1) * PROD_W'(100);
            div2_reg  <= q1;
            zero2_reg <= (q1 == '0);
        end
    end

    // bit time scaled by 100: quotient stays below 2^15
    uart_fbd_divider #(
        .DW (DIV_W),
        .QW (QUO_W),
        .SW (DIV_W + 1)
    ) u_div_bit (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v2_reg),
        .num_hi    ({1'b0, n2_reg[PROD_W-1:QUO_W]}),
        .num_lo    (n2_reg[QUO_W-1:0]),
        .den       (m_reg),
        .side_in   ({zero2_reg, div2_reg}),
        .out_valid (v3),
        .quo       (q2),
        .side_out  (side3)
    );

    // divide by 100 through a reciprocal
    assign recip = 28'(q2) * 28'd5243;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo4_reg  <= q2;
            cyc4_reg  <= recip[27:19];
            div4_reg  <= side3[DIV_W-1:0];
            zero4_reg <= side3[DIV_W];
        end
    end

    always_comb
    begin
        pct_wide   = quo4_reg - QUO_W'(cyc4_reg) * QUO_W'(100);
        pct        = pct_wide[6:0];
        tenth_prod = (15'(pct) + 15'd5) * 15'd205;
        tenth      = tenth_prod[14:11];
        if (tenth > MAX_TENTH)
            tenth = MAX_TENTH;
        sc_next    = cyc4_reg[7:0] - 8'd1;
        sp_next    = {1'b0, sc_next[7:1]} - 8'd1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (zero4_reg)
            begin
                divisor_reg  <= '0;
                overflow_reg <= 1'b0;
                sc_reg       <= '0;
                sp_reg       <= '0;
                flow_reg     <= '0;
                fhigh_reg    <= '0;
            end
            else
            begin
                divisor_reg  <= div4_reg[15:0];
                overflow_reg <= (div4_reg[DIV_W-1:16] != '0);
                sc_reg       <= sc_next;
                sp_reg       <= sp_next;
                flow_reg     <= frac_low(tenth);
                fhigh_reg    <= frac_high(tenth);
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign divisor          = divisor_reg;
    assign divisor_overflow = overflow_reg;
    assign sample_count     = sc_reg;
    assign sample_point     = sp_reg;
    assign fraction_low     = flow_reg;
    assign fraction_high    = fhigh_reg;

endmodule

@@ tb/uart_fractional_baud_divisor_core_tb.sv @@
// testbench for the fractional uart baud divisor core: random and directed clock rates
`timescale 1ns / 100ps

module uart_fractional_baud_divisor_core_tb;
    import uart_fbd_pkg::*;

    typedef struct {
        logic [15:0] divisor;
        logic        overflow;
        logic [7:0]  sample_count;
        logic [7:0]  sample_point;
        logic [7:0]  fraction_low;
        logic [1:0]  fraction_high;
    } baud_setting_t;

    class baud_scoreboard;
        baud_setting_t pending_settings[$];
        logic [BAUD_W-1:0] baud;
        int errors;

        function new();
            baud = BAUD_RESET;
            errors = 0;
        endfunction

        function baud_setting_t compute_setting(logic [CLK_W-1:0] clk_rate);
            baud_setting_t s;
            logic [63:0] b, c, div, cyc, pct, tenth;
            logic [7:0] lo_tab[11];
            logic [1:0] hi_tab[11];
            lo_tab = '{8'h00, 8'h01, 8'h05, 8'h15, 8'h55, 8'h57, 8'h57, 8'h77, 8'h7f,
                       8'hff, 8'hff};
            hi_tab = '{2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd3};
            s = '{16'd0, 1'b0, 8'd0, 8'd0, 8'd0, 2'd0};
            b = (baud == 0) ? 64'd1 : 64'(baud);
            c = 64'(clk_rate);
            div = (c + 256 * b - 1) / (256 * b);
            if (div == 0)
                return s;
            cyc = c / (b * div);
            s.sample_count = 8'(cyc - 1);
            s.sample_point = 8'((s.sample_count >> 1) - 8'd1);
            pct = ((c * 100) / b / div) % 100;
            tenth = (pct + 5) / 10;
            if (tenth > 10)
                tenth = 10;
            s.divisor = div[15:0];
            s.overflow = div > 64'hffff;
            s.fraction_low = lo_tab[tenth];
            s.fraction_high = hi_tab[tenth];
            return s;
        endfunction

        function void note_clock(logic [CLK_W-1:0] clk_rate);
            pending_settings.push_back(compute_setting(clk_rate));
        endfunction

        function void check_setting(baud_setting_t got);
            baud_setting_t e;
            if (pending_settings.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result divisor %0d", $time, got.divisor);
                return;
            end
            e = pending_settings.pop_front();
            if (got.divisor !== e.divisor)
            begin
                errors++;
                $display("%0t: divisor exp %0d got %0d", $time, e.divisor, got.divisor);
            end
            if (got.overflow !== e.overflow)
            begin
                errors++;
                $display("%0t: overflow exp %0d got %0d", $time, e.overflow, got.overflow);
            end
            if (got.sample_count !== e.sample_count)
            begin
                errors++;
                $display("%0t: sample_count exp %0d got %0d", $time, e.sample_count,
                         got.sample_count);
            end
            if (got.sample_point !== e.sample_point)
            begin
                errors++;
                $display("%0t: sample_point exp %0d got %0d", $time, e.sample_point,
                         got.sample_point);
            end
            if (got.fraction_low !== e.fraction_low)
            begin
                errors++;
                $display("%0t: fraction_low exp %h got %h", $time, e.fraction_low,
                         got.fraction_low);
            end
            if (got.fraction_high !== e.fraction_high)
            begin
                errors++;
                $display("%0t: fraction_high exp %0d got %0d", $time, e.fraction_high,
                         got.fraction_high);
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [BAUD_W-1:0] cfg_wdata;
    logic              in_valid;
    logic              in_stall;
    logic [CLK_W-1:0]  clock_hz;
    logic              out_valid;
    logic              out_stall;
    logic [15:0]       divisor;
    logic              divisor_overflow;
    logic [7:0]        sample_count;
    logic [7:0]        sample_point;
    logic [7:0]        fraction_low;
    logic [1:0]        fraction_high;

    baud_scoreboard sb;
    int cycles;
    bit stall_quiet;

    uart_fractional_baud_divisor_core dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .clock_hz(clock_hz),
        .out_valid(out_valid), .out_stall(out_stall), .divisor(divisor),
        .divisor_overflow(divisor_overflow), .sample_count(sample_count),
        .sample_point(sample_point), .fraction_low(fraction_low),
        .fraction_high(fraction_high)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    task automatic send_clock(logic [CLK_W-1:0] v);
        int g;
        g = stall_quiet ? 0 : gap_len();
        if (g != 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        in_valid <= 1'b1;
        clock_hz <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_clock(v);
        @(negedge clk);
    endtask

    task automatic write_baud(logic [BAUD_W-1:0] v);
        in_valid <= 1'b0;
        while (sb.pending_settings.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.baud = v;
    endtask

    function automatic logic [CLK_W-1:0] rand_clock();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return $urandom();
        if (r < 7)
            return 32'(64'(sb.baud) * $urandom_range(1, 4000));
        if (r < 9)
            return $urandom_range(0, 5000);
        return 32'hffffffff - $urandom_range(0, 1000);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_setting(baud_setting_t'{divisor, divisor_overflow, sample_count,
                                             sample_point, fraction_low, fraction_high});
    end

    always @(negedge clk)
    begin
        if (stall_quiet)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < 25);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 400000)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        logic [BAUD_W-1:0] bauds[8];
        sb = new();
        cycles = 0;
        stall_quiet = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        clock_hz = '0;
        out_stall = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_clock(32'd0);
        send_clock(32'd1);
        send_clock(32'hffffffff);
        send_clock(32'd1843200);
        send_clock(32'd40000000);
        send_clock(32'd115199);
        send_clock(32'd230400);
        send_clock(32'h55555555);
        send_clock(32'haaaaaaaa);
        write_baud(22'd0);
        send_clock(32'd0);
        send_clock(32'd1);
        send_clock(32'd257);
        send_clock(32'hffffffff);
        send_clock(32'd16777216);
        write_baud(22'h3fffff);
        send_clock(32'd1);
        send_clock(32'hffffffff);
        send_clock(32'd4194303);
        write_baud(22'd1);
        send_clock(32'd25599);
        send_clock(32'd1234567);

        bauds = '{22'd115200, 22'd9600, 22'd1, 22'd4000000, 22'h3fffff, 22'd300,
                  22'd921600, 22'd0};
        foreach (bauds[i])
        begin
            if (i == 7)
                write_baud(22'($urandom_range(1, 4000000)));
            else
                write_baud(bauds[i]);
            for (int k = 0; k < 145; k++)
            begin
                stall_quiet = (k >= 100 && k < 120);
                send_clock(rand_clock());
            end
            stall_quiet = 0;
        end

        in_valid <= 1'b0;
        while (sb.pending_settings.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
